FILE: src/char_lcd_write_formatter_assert.svh
// Assertion macros for the character-LCD write formatter
`ifndef CHAR_LCD_WRITE_FORMATTER_ASSERT_SVH
`define CHAR_LCD_WRITE_FORMATTER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define CLWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CLWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/clwf_pkg.sv
// Package: types, codes and constants of the character-LCD write formatter
`default_nettype none

package clwf_pkg;

  localparam int CMD_W      = 2;
  localparam int VALUE_W    = 16;
  localparam int POS_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int NIBBLE_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int DIGITS     = 5;
  localparam int IDX_W      = 3;
  localparam int QUOT_W     = 13;
  localparam int REM_W      = 4;
  localparam int PROD_W     = 32;

  localparam logic [VALUE_W-1:0] DIV10_MAGIC = 16'hCCCD;
  localparam int                 DIV10_SHIFT = 19;

  localparam logic [BYTE_W-1:0] ASCII_ZERO     = 8'd48;
  localparam logic [BYTE_W-1:0] POS_BASE_RESET = 8'h80;
  localparam logic [BYTE_W-1:0] ROW2_OFFSET    = 8'h40;
  localparam logic [BYTE_W-1:0] ROW3_OFFSET    = 8'h14;
  localparam logic [BYTE_W-1:0] ROW4_OFFSET    = 8'h54;

  typedef enum logic [CMD_W-1:0] {
    CMD_COMMAND  = 2'd0,
    CMD_DATA     = 2'd1,
    CMD_POSITION = 2'd2,
    CMD_NUMBER   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOUR_BIT = 1'b0,
    REG_POS_BASE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [BYTE_W-1:0] row_offset(input logic [POS_W-1:0] row);
    logic [BYTE_W-1:0] off;
    case (row)
      8'd2:         off = ROW2_OFFSET;
      8'd3:         off = ROW3_OFFSET;
      8'd0, 8'd4:   off = ROW4_OFFSET;
      default:      off = '0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

FILE: src/clwf_in_if.sv
// Request channel interface
`default_nettype none

interface clwf_in_if import clwf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   row;
  logic [POS_W-1:0]   column;

  modport source (output valid, cmd, value, row, column, input ready);
  modport sink   (input valid, cmd, value, row, column, output ready);
endinterface

`default_nettype wire

FILE: src/clwf_out_if.sv
// Bus transfer channel interface
`default_nettype none

interface clwf_out_if import clwf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] bus_value;
  logic              reg_select;
  logic              last_transfer;

  modport source (output valid, bus_value, reg_select, last_transfer, input ready);
  modport sink   (input valid, bus_value, reg_select, last_transfer, output ready);
endinterface

`default_nettype wire

FILE: src/char_lcd_write_formatter.sv
// Character-LCD write formatter: turns requests into register-select/last-tagged bus transfers.
// A command, data or set-position request is accepted and then sends one transfer per cycle
// (one byte, or two nibbles in four-bit mode) while the output is not stalled. A print-number
// request is accepted, extracts one decimal digit per cycle through the divide-by-ten unit (one
// to five digits), then sends one transfer per cycle while the output is not stalled. The next
// item is taken once the last transfer sits in the output register.
`default_nettype none
`include "char_lcd_write_formatter_assert.svh"

module char_lcd_write_formatter import clwf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  clwf_in_if.sink               in_ch,
  clwf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               nib_r, nib_nxt;
  logic               rs_r, rs_nxt;
  logic [VALUE_W-1:0] work_r, work_nxt;
  logic [BYTE_W-1:0]  byte_r [DIGITS];

  logic               four_bit_r;
  logic [BYTE_W-1:0]  pos_base_r;

  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_bus_r, out_bus_nxt;
  logic               out_rs_r, out_rs_nxt;
  logic               out_last_r, out_last_nxt;

  logic               buf_we;
  logic [IDX_W-1:0]   buf_addr;
  logic [BYTE_W-1:0]  buf_wdata;

  logic [QUOT_W-1:0]  div_q;
  logic [REM_W-1:0]   div_r;
  logic [BYTE_W-1:0]  cur_byte;
  logic [BYTE_W-1:0]  pos_addr;
  logic               in_accept;
  logic               slot_free;

  clwf_div10 u_div10 (
    .dividend  (work_r),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign in_accept            = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.bus_value     = out_bus_r;
  assign out_ch.reg_select    = out_rs_r;
  assign out_ch.last_transfer = out_last_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign cur_byte  = byte_r[idx_r];
  assign pos_addr  = pos_base_r + row_offset(in_ch.row) + in_ch.column - 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= 1'b0;
      pos_base_r <= POS_BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOUR_BIT: four_bit_r <= cfg_data[0];
        REG_POS_BASE: pos_base_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      nib_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      nib_r       <= nib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r       <= rs_nxt;
    work_r     <= work_nxt;
    out_bus_r  <= out_bus_nxt;
    out_rs_r   <= out_rs_nxt;
    out_last_r <= out_last_nxt;
    if (buf_we) begin
      byte_r[buf_addr] <= buf_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    nib_nxt       = nib_r;
    rs_nxt        = rs_r;
    work_nxt      = work_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_bus_nxt   = out_bus_r;
    out_rs_nxt    = out_rs_r;
    out_last_nxt  = out_last_r;
    buf_we        = 1'b0;
    buf_addr      = idx_r;
    buf_wdata     = in_ch.value[BYTE_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          idx_nxt  = '0;
          nib_nxt  = 1'b0;
          buf_addr = '0;
          work_nxt = in_ch.value;
          unique case (cmd_t'(in_ch.cmd))
            CMD_COMMAND: begin
              buf_we    = 1'b1;
              rs_nxt    = 1'b0;
              state_nxt = ST_EMIT;
            end
            CMD_DATA: begin
              buf_we    = 1'b1;
              rs_nxt    = 1'b1;
              state_nxt = ST_EMIT;
            end
            CMD_POSITION: begin
              buf_we    = 1'b1;
              buf_wdata = pos_addr;
              rs_nxt    = 1'b0;
              state_nxt = ST_EMIT;
            end
            CMD_NUMBER: begin
              rs_nxt    = 1'b1;
              state_nxt = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        buf_we    = 1'b1;
        buf_wdata = ASCII_ZERO + BYTE_W'(div_r);
        work_nxt  = VALUE_W'(div_q);
        if (div_q == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rs_nxt    = rs_r;
          if (four_bit_r && !nib_r) begin
            out_bus_nxt  = BYTE_W'(cur_byte[BYTE_W-1 -: NIBBLE_W]);
            out_last_nxt = 1'b0;
            nib_nxt      = 1'b1;
          end else begin
            out_bus_nxt  = four_bit_r ? BYTE_W'(cur_byte[NIBBLE_W-1:0]) : cur_byte;
            out_last_nxt = (idx_r == '0);
            nib_nxt      = 1'b0;
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `CLWF_ASSERT_NOW(a_idx_bound, 1'b1, idx_r < IDX_W'(DIGITS), "digit index past buffer")
  `CLWF_ASSERT_NEXT(a_byte_req, in_accept && in_ch.cmd != CMD_NUMBER,
                    state_r == ST_EMIT && idx_r == '0,
                    "byte request did not go straight to transfer")
  `CLWF_ASSERT_NEXT(a_num_req, in_accept && in_ch.cmd == CMD_NUMBER,
                    state_r == ST_DIV && idx_r == '0,
                    "number request did not start digit extraction")

endmodule

`default_nettype wire

FILE: src/clwf_div10.sv
// Divide-by-ten unit: reciprocal multiply plus remainder fix-up
`default_nettype none

module clwf_div10 import clwf_pkg::*; (
  input  logic [VALUE_W-1:0] dividend,
  output logic [QUOT_W-1:0]  quotient,
  output logic [REM_W-1:0]   remainder
);

  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] q_ext;
  logic [VALUE_W-1:0] q_times10;
  logic [VALUE_W-1:0] diff;

  // exact for every 16-bit dividend
  assign prod      = PROD_W'(dividend) * PROD_W'(DIV10_MAGIC);
  assign quotient  = prod[DIV10_SHIFT +: QUOT_W];
  assign q_ext     = VALUE_W'(quotient);
  assign q_times10 = (q_ext << 3) + (q_ext << 1);
  assign diff      = dividend - q_times10;
  assign remainder = diff[REM_W-1:0];

endmodule

`default_nettype wire

FILE: bench/char_lcd_write_formatter_tb.sv
// Testbench for char_lcd_write_formatter: directed table plus random requests, scoreboarded
`default_nettype none

module char_lcd_write_formatter_tb;
  import clwf_pkg::*;

  localparam int N_DIRECTED  = 25;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 22;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [BYTE_W-1:0] bus_value;
    logic              reg_select;
    logic              last_transfer;
  } transfer_t;

  typedef struct {
    cmd_t               cmd;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
    bit                 typed;
    logic [BYTE_W-1:0]  exp_bus;
  } request_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  clwf_in_if  in_if ();
  clwf_out_if out_if ();

  char_lcd_write_formatter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  transfer_t         pending_transfers[$];
  bit                mode_four_bit;
  logic [BYTE_W-1:0] addr_base;
  request_t          typed_req;
  bit                idle_on;
  int                fail_count;
  int                stuck_cycles;

  // typed-in expectations hold for the reset setting: byte bus, base 0x80
  request_t directed_reqs [N_DIRECTED] = '{
    '{CMD_COMMAND,  16'h0000, 8'd0,   8'd0,   1'b1, 8'h00},
    '{CMD_COMMAND,  16'h00FF, 8'd255, 8'd255, 1'b1, 8'hFF},
    '{CMD_COMMAND,  16'hABCD, 8'd0,   8'd0,   1'b1, 8'hCD},
    '{CMD_DATA,     16'h0041, 8'd0,   8'd0,   1'b1, 8'h41},
    '{CMD_DATA,     16'hFFFF, 8'd255, 8'd255, 1'b1, 8'hFF},
    '{CMD_DATA,     16'hFF00, 8'd0,   8'd0,   1'b1, 8'h00},
    '{CMD_POSITION, 16'h0000, 8'd1,   8'd1,   1'b1, 8'h80},
    '{CMD_POSITION, 16'hFFFF, 8'd2,   8'd1,   1'b1, 8'hC0},
    '{CMD_POSITION, 16'h0000, 8'd3,   8'd1,   1'b1, 8'h94},
    '{CMD_POSITION, 16'h0000, 8'd4,   8'd1,   1'b1, 8'hD4},
    '{CMD_POSITION, 16'h0000, 8'd0,   8'd1,   1'b1, 8'hD4},
    '{CMD_POSITION, 16'h0000, 8'd5,   8'd1,   1'b1, 8'h80},
    '{CMD_POSITION, 16'h0000, 8'd255, 8'd255, 1'b1, 8'h7E},
    '{CMD_POSITION, 16'h0000, 8'd4,   8'd0,   1'b1, 8'hD3},
    '{CMD_POSITION, 16'h1234, 8'd2,   8'd20,  1'b1, 8'hD3},
    '{CMD_POSITION, 16'h0000, 8'd1,   8'd0,   1'b1, 8'h7F},
    '{CMD_NUMBER,   16'd0,    8'd0,   8'd0,   1'b1, 8'h30},
    '{CMD_NUMBER,   16'd65535, 8'd0,  8'd0,   1'b0, 8'h00},
    '{CMD_NUMBER,   16'd9,    8'd0,   8'd0,   1'b0, 8'h00},
    '{CMD_NUMBER,   16'd10,   8'd0,   8'd0,   1'b0, 8'h00},
    '{CMD_NUMBER,   16'd99,   8'd0,   8'd0,   1'b0, 8'h00},
    '{CMD_NUMBER,   16'd100,  8'd0,   8'd0,   1'b0, 8'h00},
    '{CMD_NUMBER,   16'd10000, 8'd255, 8'd255, 1'b0, 8'h00},
    '{CMD_NUMBER,   16'd12345, 8'd0,  8'd0,   1'b0, 8'h00},
    '{CMD_NUMBER,   16'd1,    8'd0,   8'd0,   1'b0, 8'h00}
  };

  always #1 clk = ~clk;

  function automatic void queue_bus_byte(logic [BYTE_W-1:0] b, logic rs);
    if (mode_four_bit) begin
      pending_transfers.push_back('{{4'h0, b[7:4]}, rs, 1'b0});
      pending_transfers.push_back('{{4'h0, b[3:0]}, rs, 1'b0});
    end else begin
      pending_transfers.push_back('{b, rs, 1'b0});
    end
  endfunction

  function automatic void predict_transfers(cmd_t c, logic [VALUE_W-1:0] v,
                                            logic [POS_W-1:0] r, logic [POS_W-1:0] col);
    logic [BYTE_W-1:0] off;
    logic [BYTE_W-1:0] addr;
    logic [3:0]        digs [DIGITS];
    logic [VALUE_W-1:0] rest;
    int                n;
    int                tail;
    case (c)
      CMD_COMMAND: queue_bus_byte(v[7:0], 1'b0);
      CMD_DATA:    queue_bus_byte(v[7:0], 1'b1);
      CMD_POSITION: begin
        if (r == 8'd1 || r > 8'd4) off = '0;
        else if (r == 8'd2)        off = ROW2_OFFSET;
        else if (r == 8'd3)        off = ROW3_OFFSET;
        else                       off = ROW4_OFFSET;
        addr = addr_base + off + col - 8'd1;
        queue_bus_byte(addr, 1'b0);
      end
      default: begin
        n = 0;
        rest = v;
        do begin
          digs[n] = 4'(rest % 10);
          rest = rest / 10;
          n++;
        end while (rest != 0);
        for (int i = n - 1; i >= 0; i--) queue_bus_byte(ASCII_ZERO + digs[i], 1'b1);
      end
    endcase
    tail = pending_transfers.size() - 1;
    pending_transfers[tail].last_transfer = 1'b1;
  endfunction

  function automatic request_t make_random_request();
    request_t rq;
    int       ndig;
    rq.cmd = cmd_t'($urandom_range(0, 3));
    rq.value = VALUE_W'($urandom);
    rq.row = POS_W'($urandom);
    rq.column = POS_W'($urandom);
    rq.typed = 1'b0;
    rq.exp_bus = '0;
    if (rq.cmd == CMD_POSITION && $urandom_range(0, 3) != 0) begin
      rq.row = POS_W'($urandom_range(0, 5));
      rq.column = POS_W'($urandom_range(1, 20));
    end
    if (rq.cmd == CMD_NUMBER) begin
      ndig = $urandom_range(0, 6);
      case (ndig)
        0: rq.value = 16'd0;
        1: rq.value = VALUE_W'($urandom_range(1, 9));
        2: rq.value = VALUE_W'($urandom_range(10, 99));
        3: rq.value = VALUE_W'($urandom_range(100, 999));
        4: rq.value = VALUE_W'($urandom_range(1000, 9999));
        5: rq.value = VALUE_W'($urandom_range(10000, 65535));
        default: ;
      endcase
    end
    return rq;
  endfunction

  task automatic send_request(request_t rq);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_if.valid  <= 1'b0;
      in_if.cmd    <= CMD_W'($urandom);
      in_if.value  <= VALUE_W'($urandom);
      in_if.row    <= POS_W'($urandom);
      in_if.column <= POS_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    typed_req     = rq;
    in_if.valid  <= 1'b1;
    in_if.cmd    <= rq.cmd;
    in_if.value  <= rq.value;
    in_if.row    <= rq.row;
    in_if.column <= rq.column;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_transfers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_FOUR_BIT) mode_four_bit = data[0];
    else                     addr_base = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stall bursts while idling is on
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // scoreboard: check the transfer first, then predict for the item taken at this edge
  always @(posedge clk) begin : scoreboard
    transfer_t want;
    logic      rs;
    if (rst_n) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (pending_transfers.size() == 0) begin
          $error("unexpected transfer: bus_value %0h reg_select %0b last_transfer %0b",
                 out_if.bus_value, out_if.reg_select, out_if.last_transfer);
          fail_count++;
        end else begin
          want = pending_transfers.pop_front();
          if (out_if.bus_value !== want.bus_value) begin
            $error("bus_value: expected %0h, got %0h", want.bus_value, out_if.bus_value);
            fail_count++;
          end
          if (out_if.reg_select !== want.reg_select) begin
            $error("reg_select: expected %0b, got %0b", want.reg_select, out_if.reg_select);
            fail_count++;
          end
          if (out_if.last_transfer !== want.last_transfer) begin
            $error("last_transfer: expected %0b, got %0b",
                   want.last_transfer, out_if.last_transfer);
            fail_count++;
          end
        end
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        if (typed_req.typed) begin
          rs = (typed_req.cmd == CMD_DATA || typed_req.cmd == CMD_NUMBER);
          pending_transfers.push_back('{typed_req.exp_bus, rs, 1'b1});
        end else begin
          predict_transfers(cmd_t'(in_if.cmd), in_if.value, in_if.row, in_if.column);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                 (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] base_seq [N_PHASES];
    bit                four_seq [N_PHASES];
    logic [BYTE_W-1:0] base;
    base_seq = '{8'h80, 8'h00, 8'hFF, 8'h37, 8'hC9, 8'hFF};
    four_seq = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FOUR_BIT;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_COMMAND;
    in_if.value = '0;
    in_if.row = '0;
    in_if.column = '0;
    typed_req = directed_reqs[0];
    typed_req.typed = 1'b0;
    mode_four_bit = 1'b0;
    addr_base = POS_BASE_RESET;
    idle_on = 1'b1;
    fail_count = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_request(directed_reqs[i]);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      base = (p == 3 || p == 4) ? BYTE_W'($urandom) : base_seq[p];
      write_reg(REG_FOUR_BIT, {CFG_DATA_W'($urandom) & 8'hFE} | CFG_DATA_W'(four_seq[p]));
      write_reg(REG_POS_BASE, base);
      idle_on = (p != 1 && p != N_PHASES - 1);
      repeat (PHASE_ITEMS) send_request(make_random_request());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_transfers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
